/* design/ext2bm_pkg.sv */
// ext2bm_pkg: shared types and constants for the ext2 block map walker.
// Used by ext2bm_start_dec, ext2bm_word_step and ext2_block_map_walker.
package ext2bm_pkg;

	// inode slot layout defaults
	localparam int DEF_DIRECT_SLOTS = 12;
	localparam int DEF_TOTAL_SLOTS  = 15;

	// 1024-byte base block, 256 pointers per base block
	localparam int BASE_BLOCK_SHIFT = 10;
	localparam int BASE_PTR_SHIFT   = 8;

	localparam int LBS_W    = 3;
	localparam int OFFSET_W = 48;
	localparam int BLOCK_W  = 32;
	localparam int SLOT_W   = 4;
	localparam int ADDR_W   = 64;
	localparam int LEVEL_W  = 2;
	// cumulative range bounds reach just under 2^46
	localparam int BOUND_W  = 48;

	typedef enum logic [0:0] {
		CMD_START = 1'b0,
		CMD_WORD  = 1'b1
	} command_t;

	typedef enum logic [0:0] {
		CFG_LOG_BLOCK_SIZE = 1'b0,
		CFG_PART_OFFSET    = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_FETCH_SLOT = 3'd0,
		ST_FETCH_PTR  = 3'd1,
		ST_MAPPED     = 3'd2,
		ST_HOLE       = 3'd3,
		ST_RANGE      = 3'd4,
		ST_IDLE_WORD  = 3'd5
	} status_t;

	typedef struct packed {
		logic                 waiting;
		logic [LEVEL_W-1:0]   levels_left;
		logic [BLOCK_W-1:0]   remainder;
	} walk_state_t;

	typedef struct packed {
		status_t              status;
		logic [SLOT_W-1:0]    slot;
		logic [ADDR_W-1:0]    address;
	} result_t;

endpackage

/* design/ext2_block_map_walker.sv */
// ext2_block_map_walker: top level of the ext2 logical-to-device block mapper.
// Depends on ext2bm_pkg, ext2bm_start_dec and ext2bm_word_step.
//
// Maps a file's logical block to a device byte address through the inode's
// direct slots and the single, double and triple indirect slots. A start beat
// (command 0) answers with the inode slot to fetch; each word beat (command 1)
// answers with the next pointer word address, the mapped block address, or a
// hole. Out-of-range blocks and words sent while idle get their own status.
// Every input beat yields exactly one result beat. An input beat is captured
// in an input register, and the result is computed combinationally from it and
// held in an output register; one beat per cycle is sustained whenever
// result_ready stays high. The walk state is updated in the same cycle a beat
// moves to the output register, so back-to-back beats see each other's effect.
// Configuration writes take effect at once and are always accepted.
module ext2_block_map_walker
	import ext2bm_pkg::*;
#(
	parameter int DIRECT_SLOTS = DEF_DIRECT_SLOTS,
	parameter int TOTAL_SLOTS  = DEF_TOTAL_SLOTS
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration write channel
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [OFFSET_W-1:0] cfg_data,
	// input beats
	input  logic                item_valid,
	output logic                item_ready,
	input  logic                command,
	input  logic [BLOCK_W-1:0]  logical_block,
	input  logic [BLOCK_W-1:0]  word_value,
	// result beats
	output logic                result_valid,
	input  logic                result_ready,
	output logic [2:0]          status,
	output logic [SLOT_W-1:0]   slot,
	output logic [ADDR_W-1:0]   address
);

	// configuration registers
	logic [LBS_W-1:0]    log_block_size_q;
	logic [OFFSET_W-1:0] part_offset_q;

	// input stage
	logic                valid_s1;
	logic                command_s1;
	logic [BLOCK_W-1:0]  logical_block_s1;
	logic [BLOCK_W-1:0]  word_value_s1;

	// output stage
	logic                valid_s2;
	result_t             res_s2;

	// walk state
	walk_state_t         walk_q;

	result_t             start_res, word_res, res_d;
	walk_state_t         start_nxt, word_nxt, walk_d;
	logic                advance;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_block_size_q <= '0;
			part_offset_q    <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_LOG_BLOCK_SIZE: log_block_size_q <= cfg_data[LBS_W-1:0];
				CFG_PART_OFFSET:    part_offset_q    <= cfg_data;
				default:            ;
			endcase
		end
	end

	// a beat leaves the input register when the output register is free or
	// is being drained this cycle
	assign advance    = valid_s1 && (!valid_s2 || result_ready);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			command_s1       <= command;
			logical_block_s1 <= logical_block;
			word_value_s1    <= word_value;
		end
	end

	ext2bm_start_dec #(
		.DIRECT_SLOTS (DIRECT_SLOTS),
		.TOTAL_SLOTS  (TOTAL_SLOTS)
	) u_start_dec (
		.log_block_size (log_block_size_q),
		.logical_block  (logical_block_s1),
		.res            (start_res),
		.nxt            (start_nxt)
	);

	ext2bm_word_step u_word_step (
		.log_block_size (log_block_size_q),
		.part_offset    (part_offset_q),
		.word_value     (word_value_s1),
		.cur            (walk_q),
		.res            (word_res),
		.nxt            (word_nxt)
	);

	// a start always drops any walk in progress
	always_comb begin
		if (command_s1 == CMD_START) begin
			res_d  = start_res;
			walk_d = start_nxt;
		end else begin
			res_d  = word_res;
			walk_d = word_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q <= '{waiting: 1'b0, levels_left: '0, remainder: '0};
		end else if (advance) begin
			walk_q <= walk_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || result_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_d;
		end
	end

	assign result_valid = valid_s2;
	assign status       = res_s2.status;
	assign slot         = res_s2.slot;
	assign address      = res_s2.address;

endmodule

/* design/ext2bm_start_dec.sv */
// ext2bm_start_dec: decodes a logical block into an inode slot and walk state.
// Depends on ext2bm_pkg.
module ext2bm_start_dec
	import ext2bm_pkg::*;
#(
	parameter int DIRECT_SLOTS = DEF_DIRECT_SLOTS,
	parameter int TOTAL_SLOTS  = DEF_TOTAL_SLOTS
) (
	input  logic [LBS_W-1:0]   log_block_size,
	input  logic [BLOCK_W-1:0] logical_block,
	output result_t            res,
	output walk_state_t        nxt
);

	localparam int NUM_IND = (TOTAL_SLOTS - DIRECT_SLOTS) > 3 ? 3 : (TOTAL_SLOTS - DIRECT_SLOTS);
	localparam logic [SLOT_W-1:0]  SLOT_SINGLE = SLOT_W'(DIRECT_SLOTS);
	localparam logic [SLOT_W-1:0]  SLOT_DOUBLE = SLOT_W'(DIRECT_SLOTS + 1);
	localparam logic [SLOT_W-1:0]  SLOT_TRIPLE = SLOT_W'(DIRECT_SLOTS + 2);
	localparam logic [BOUND_W-1:0] BND_DIRECT  = BOUND_W'(DIRECT_SLOTS);

	logic [3:0]         lppb;
	logic [4:0]         sh2;
	logic [5:0]         sh3;
	logic [BOUND_W-1:0] bnd1, bnd2, bnd3;
	logic [BOUND_W-1:0] n48, base;

	// range sizes are distinct powers of two above the direct count, so the
	// cumulative bounds are plain ORs
	always_comb begin
		lppb = 4'(BASE_PTR_SHIFT) + 4'(log_block_size);
		sh2  = {lppb, 1'b0};
		sh3  = 6'(sh2) + 6'(lppb);
		bnd1 = BND_DIRECT | (BOUND_W'(1) << lppb);
		bnd2 = bnd1 | (BOUND_W'(1) << sh2);
		bnd3 = bnd2 | (BOUND_W'(1) << sh3);
		n48  = BOUND_W'(logical_block);
	end

	always_comb begin
		res         = '{status: ST_RANGE, slot: '0, address: '0};
		nxt         = '{waiting: 1'b0, levels_left: '0, remainder: '0};
		base        = BND_DIRECT;
		if (n48 < BND_DIRECT) begin
			res.status  = ST_FETCH_SLOT;
			res.slot    = logical_block[SLOT_W-1:0];
			nxt.waiting = 1'b1;
		end else if (NUM_IND >= 1 && n48 < bnd1) begin
			res.status      = ST_FETCH_SLOT;
			res.slot        = SLOT_SINGLE;
			nxt.waiting     = 1'b1;
			nxt.levels_left = 2'd1;
		end else if (NUM_IND >= 2 && n48 < bnd2) begin
			res.status      = ST_FETCH_SLOT;
			res.slot        = SLOT_DOUBLE;
			nxt.waiting     = 1'b1;
			nxt.levels_left = 2'd2;
			base            = bnd1;
		end else if (NUM_IND >= 3 && n48 < bnd3) begin
			res.status      = ST_FETCH_SLOT;
			res.slot        = SLOT_TRIPLE;
			nxt.waiting     = 1'b1;
			nxt.levels_left = 2'd3;
			base            = bnd2;
		end
		if (nxt.levels_left != 2'd0) begin
			nxt.remainder = BLOCK_W'(n48 - base);
		end
	end

endmodule

/* design/ext2bm_word_step.sv */
// ext2bm_word_step: handles a fetched slot or pointer word for the walk.
// Depends on ext2bm_pkg.
module ext2bm_word_step
	import ext2bm_pkg::*;
(
	input  logic [LBS_W-1:0]    log_block_size,
	input  logic [OFFSET_W-1:0] part_offset,
	input  logic [BLOCK_W-1:0]  word_value,
	input  walk_state_t         cur,
	output result_t             res,
	output walk_state_t         nxt
);

	logic [3:0]         lppb;
	logic [4:0]         bshift;
	logic [4:0]         sh;
	logic [15:0]        digit;
	logic [ADDR_W-1:0]  blk;

	always_comb begin
		lppb   = 4'(BASE_PTR_SHIFT) + 4'(log_block_size);
		bshift = 5'(BASE_BLOCK_SHIFT) + 5'(log_block_size);
		case (cur.levels_left)
			2'd2:    sh = 5'(lppb);
			2'd3:    sh = {lppb, 1'b0};
			default: sh = '0;
		endcase
		digit = 16'((cur.remainder >> sh) & ((BLOCK_W'(1) << lppb) - BLOCK_W'(1)));
		// block number shifted clears bshift low bits; digit*4 fits below them
		blk   = ADDR_W'(word_value) << bshift;
	end

	always_comb begin
		res = '{status: ST_IDLE_WORD, slot: '0, address: '0};
		nxt = cur;
		if (cur.waiting) begin
			if (word_value == '0) begin
				res.status = ST_HOLE;
				nxt        = '{waiting: 1'b0, levels_left: '0, remainder: '0};
			end else if (cur.levels_left == 2'd0) begin
				res.status    = ST_MAPPED;
				res.address   = blk + ADDR_W'(part_offset);
				nxt.waiting   = 1'b0;
				nxt.remainder = '0;
			end else begin
				res.status      = ST_FETCH_PTR;
				res.address     = (blk | (ADDR_W'(digit) << 2)) + ADDR_W'(part_offset);
				nxt.levels_left = cur.levels_left - 2'd1;
				nxt.remainder   = cur.remainder & ((BLOCK_W'(1) << sh) - BLOCK_W'(1));
			end
		end
	end

endmodule

/* tb/tb_ext2_block_map_walker.sv */
// Self-checking testbench for ext2_block_map_walker: directed and random walks
// through direct, single, double and triple indirect slots, against a predictor.
// Depends on ext2bm_pkg and the ext2_block_map_walker RTL.
`timescale 1ns / 1ps

module tb_ext2_block_map_walker;
	import ext2bm_pkg::*;

	localparam int DIRECT_N        = DEF_DIRECT_SLOTS;
	localparam int TOTAL_N         = DEF_TOTAL_SLOTS;
	localparam int RANDOM_ITEMS    = 2000;
	localparam int PHASES          = 10;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int MAX_PRINTED     = 40;
	// ranges for 256 pointers per block: direct, single, double, triple
	localparam int LAST_MAPPED_LBS0 = DIRECT_N + 256 + 65536 + 16777216 - 1;

	logic                clk;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	cfg_reg_t            cfg_index;
	logic [OFFSET_W-1:0] cfg_data;
	logic                item_valid;
	logic                item_ready;
	command_t            command;
	logic [BLOCK_W-1:0]  logical_block;
	logic [BLOCK_W-1:0]  word_value;
	logic                result_valid;
	logic                result_ready;
	logic [2:0]          status;
	logic [SLOT_W-1:0]   slot;
	logic [ADDR_W-1:0]   address;

	ext2_block_map_walker #(
		.DIRECT_SLOTS(DIRECT_N),
		.TOTAL_SLOTS (TOTAL_N)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.command      (command),
		.logical_block(logical_block),
		.word_value   (word_value),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.status       (status),
		.slot         (slot),
		.address      (address)
	);

	// 10 ns clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Predictor copy of the walk state and the two registers.
	walk_state_t         walk         = '0;
	logic [LBS_W-1:0]    cfg_log_bs   = '0;
	logic [OFFSET_W-1:0] cfg_part_off = '0;

	// Results still owed by the block, oldest first.
	result_t map_results_due[$];

	int mismatches  = 0;
	int items_sent  = 0;
	int burst_left  = 0;
	bit sender_gaps = 1'b1;
	// set by a test; the sink process counts it down, holding ready low
	int hold_off    = 0;

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatches++;
		if (mismatches <= MAX_PRINTED)
			$display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
	endtask

	// One step of the mapper: updates the walk state and returns the result
	// the block owes for this beat. Registers are read as they are now.
	function automatic result_t walk_map_step(input command_t cmd,
			input logic [31:0] blk, input logic [31:0] wv);
		result_t     r;
		logic [63:0] n, span, word, base, digit, rem;
		int          ppb_sh, blk_sh, sh, slot_idx;

		r      = '0;
		ppb_sh = BASE_PTR_SHIFT + int'(cfg_log_bs);
		blk_sh = BASE_BLOCK_SHIFT + int'(cfg_log_bs);

		if (cmd == CMD_START) begin
			// a start always drops any walk in progress
			walk = '0;
			n    = {32'b0, blk};
			if (n < DIRECT_N) begin
				walk.waiting = 1'b1;
				r.status     = ST_FETCH_SLOT;
				r.slot       = SLOT_W'(n);
				return r;
			end
			n = n - DIRECT_N;
			for (int lvl = 1; lvl <= 3; lvl++) begin
				slot_idx = DIRECT_N + lvl - 1;
				// indirect slots past the inode's slot count do not exist
				if (slot_idx >= TOTAL_N)
					break;
				span = 64'd1 << (lvl * ppb_sh);
				if (n < span) begin
					walk.waiting     = 1'b1;
					walk.levels_left = LEVEL_W'(lvl);
					walk.remainder   = n[31:0];
					r.status         = ST_FETCH_SLOT;
					r.slot           = SLOT_W'(slot_idx);
					return r;
				end
				n = n - span;
			end
			r.status = ST_RANGE;
			return r;
		end

		if (!walk.waiting) begin
			r.status = ST_IDLE_WORD;
			return r;
		end

		word = {32'b0, wv};
		if (word == 0) begin
			walk     = '0;
			r.status = ST_HOLE;
			return r;
		end
		base = {16'b0, cfg_part_off} + (word << blk_sh);
		if (walk.levels_left == 0) begin
			walk.waiting   = 1'b0;
			walk.remainder = '0;
			r.status       = ST_MAPPED;
			r.address      = base;
			return r;
		end
		// take the next digit of the remainder, most significant level first
		sh               = (int'(walk.levels_left) - 1) * ppb_sh;
		rem              = {32'b0, walk.remainder};
		digit            = (rem >> sh) & ((64'd1 << ppb_sh) - 1);
		walk.levels_left = walk.levels_left - 1'b1;
		rem              = rem & ((64'd1 << sh) - 1);
		walk.remainder   = rem[31:0];
		r.status         = ST_FETCH_PTR;
		r.address        = base + (digit << 2);
		return r;
	endfunction

	// Logical block aimed at one of the ranges under the current block size,
	// often right on a range edge.
	function automatic logic [31:0] pick_block();
		logic [63:0] lo, hi, r;
		int          p;

		p = BASE_PTR_SHIFT + int'(cfg_log_bs);
		case ($urandom_range(0, 9))
			0, 1: begin
				lo = 0;
				hi = DIRECT_N - 1;
			end
			2, 3: begin
				lo = DIRECT_N;
				hi = lo + (64'd1 << p) - 1;
			end
			4, 5: begin
				lo = DIRECT_N + (64'd1 << p);
				hi = lo + (64'd1 << (2 * p)) - 1;
			end
			6, 7: begin
				lo = DIRECT_N + (64'd1 << p) + (64'd1 << (2 * p));
				hi = lo + (64'd1 << (3 * p)) - 1;
			end
			8: begin
				lo = DIRECT_N + (64'd1 << p) + (64'd1 << (2 * p)) + (64'd1 << (3 * p));
				hi = 64'hFFFF_FFFF;
			end
			default: begin
				lo = 0;
				hi = 64'hFFFF_FFFF;
			end
		endcase
		// range lies beyond 32 bits for large blocks: any block will do
		if (lo > 64'hFFFF_FFFF)
			lo = 0;
		if (hi > 64'hFFFF_FFFF)
			hi = 64'hFFFF_FFFF;
		r = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0:       r = lo;
			1:       r = hi;
			default: r = lo + r % (hi - lo + 1);
		endcase
		return r[31:0];
	endfunction

	// Fetched word: mostly nonzero, sometimes a hole or an extreme.
	function automatic logic [31:0] pick_word();
		logic [31:0] w;

		case ($urandom_range(0, 15))
			0:       w = '0;
			1:       w = 32'hFFFF_FFFF;
			2:       w = $urandom_range(1, 255);
			default: begin
				w = $urandom;
				if (w == 0)
					w = 1;
			end
		endcase
		return w;
	endfunction

	// Drop valid at the next falling edge; payload is junk while idle.
	task automatic item_idle();
		@(negedge clk);
		item_valid    = 1'b0;
		command       = command_t'($urandom_range(0, 1));
		logical_block = $urandom;
		word_value    = $urandom;
	endtask

	// Offer one beat and hold it until taken. Gaps come between bursts.
	// The caller must drive the channel again at the very next falling edge.
	task automatic send_item(input command_t cmd, input logic [31:0] blk,
			input logic [31:0] wv);
		int gap;

		if (sender_gaps && burst_left == 0) begin
			gap = $urandom_range(1, 6);
			item_idle();
			repeat (gap - 1) @(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		if (burst_left > 0)
			burst_left--;
		@(negedge clk);
		item_valid    = 1'b1;
		command       = cmd;
		logical_block = blk;
		word_value    = wv;
		do
			@(posedge clk);
		while (!item_ready);
		map_results_due.push_back(walk_map_step(cmd, blk, wv));
		items_sent++;
	endtask

	task automatic wait_drained();
		item_idle();
		while (map_results_due.size() != 0)
			@(posedge clk);
	endtask

	// Register writes only once every owed result has come back.
	task automatic write_reg(input cfg_reg_t idx, input logic [OFFSET_W-1:0] data);
		wait_drained();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == CFG_LOG_BLOCK_SIZE)
			cfg_log_bs = data[LBS_W-1:0];
		else
			cfg_part_off = data;
		@(negedge clk);
		cfg_valid = 1'b0;
		cfg_data  = {$urandom, $urandom};
	endtask

	// One random sequence: mostly a full walk with random words, sometimes
	// cut short, plus stray words and random beats as noise.
	task automatic walk_random_block();
		case ($urandom_range(0, 9))
			0: send_item(CMD_WORD, $urandom, pick_word());
			1: send_item(command_t'($urandom_range(0, 1)), $urandom, $urandom);
			default: begin
				send_item(CMD_START, pick_block(), $urandom);
				while (walk.waiting) begin
					if ($urandom_range(0, 19) == 0)
						break;
					send_item(CMD_WORD, $urandom, pick_word());
				end
			end
		endcase
	endtask

	task automatic test_direct_slots();
		write_reg(CFG_LOG_BLOCK_SIZE, '0);
		write_reg(CFG_PART_OFFSET, '0);
		send_item(CMD_START, 32'd0, $urandom);
		send_item(CMD_WORD, $urandom, 32'hFFFF_FFFF);
		send_item(CMD_START, DIRECT_N - 1, $urandom);
		send_item(CMD_WORD, $urandom, 32'd1);
	endtask

	// first single-indirect block, last triple-indirect block, first past it
	task automatic test_indirect_levels();
		send_item(CMD_START, DIRECT_N, $urandom);
		send_item(CMD_WORD, $urandom, 32'd7);
		send_item(CMD_WORD, $urandom, 32'd9);
		send_item(CMD_START, LAST_MAPPED_LBS0, $urandom);
		repeat (4)
			send_item(CMD_WORD, $urandom, $urandom_range(1, 32'hFFFF_FFFF));
		send_item(CMD_START, LAST_MAPPED_LBS0 + 1, $urandom);
	endtask

	// restart mid-walk, zero slot word, then a word with nothing waiting
	task automatic test_restart_hole_stray();
		send_item(CMD_START, 32'd300, $urandom);
		send_item(CMD_START, 32'd3, $urandom);
		send_item(CMD_WORD, $urandom, 32'd0);
		send_item(CMD_WORD, $urandom, 32'h1234_5678);
	endtask

	// block size code seven, largest offset, largest block and words
	task automatic test_register_extremes();
		write_reg(CFG_LOG_BLOCK_SIZE, 48'd7);
		write_reg(CFG_PART_OFFSET, 48'hFFFF_FFFF_FFFF);
		send_item(CMD_START, 32'hFFFF_FFFF, $urandom);
		repeat (4)
			send_item(CMD_WORD, $urandom, 32'hFFFF_FFFF);
	endtask

	// block size changes under a double-indirect walk: new size applies
	task automatic test_config_mid_walk();
		write_reg(CFG_LOG_BLOCK_SIZE, 48'd6);
		send_item(CMD_START, DIRECT_N + (1 << 14) + $urandom_range(0, 32'h0FFF_FFFF),
			$urandom);
		send_item(CMD_WORD, $urandom, $urandom_range(1, 32'hFFFF_FFFF));
		write_reg(CFG_LOG_BLOCK_SIZE, 48'd1);
		write_reg(CFG_PART_OFFSET, {$urandom, $urandom});
		send_item(CMD_WORD, $urandom, $urandom_range(1, 32'hFFFF_FFFF));
		send_item(CMD_WORD, $urandom, $urandom_range(1, 32'hFFFF_FFFF));
	endtask

	// Long output stall with the sender pushing flat out: the block fills
	// and must hold off its input without losing a beat.
	task automatic test_output_backpressure();
		int target;

		write_reg(CFG_LOG_BLOCK_SIZE, 48'd0);
		sender_gaps = 1'b0;
		hold_off    = HOLD_OFF_CYCLES;
		target      = items_sent + 40;
		while (items_sent < target)
			walk_random_block();
		sender_gaps = 1'b1;
	endtask

	// Phases of random walks, each under its own register setting; the first
	// two phases take the smallest and largest in-range settings.
	task automatic test_random_walks();
		logic [63:0] rnd;
		logic [2:0]  lbs;
		logic [47:0] off;
		int          target;

		for (int ph = 0; ph < PHASES; ph++) begin
			rnd = {$urandom, $urandom};
			lbs = (ph == 0) ? 3'd0 : (ph == 1) ? 3'd6 : 3'($urandom_range(0, 6));
			off = (ph == 0) ? 48'd0 : (ph == 1) ? 48'hFFFF_FFFF_FFFF
				: 48'({$urandom, $urandom});
			// upper data bits of the size write are junk the block drops
			if ($urandom_range(0, 1)) begin
				write_reg(CFG_LOG_BLOCK_SIZE, {rnd[47:3], lbs});
				write_reg(CFG_PART_OFFSET, off);
			end else begin
				write_reg(CFG_PART_OFFSET, off);
				write_reg(CFG_LOG_BLOCK_SIZE, {rnd[47:3], lbs});
			end
			sender_gaps = (ph % 3 != 2);
			target      = items_sent + RANDOM_ITEMS / PHASES;
			while (items_sent < target)
				walk_random_block();
		end
		sender_gaps = 1'b1;
	endtask

	// Result sink: switches among randomly chosen stall modes (always ready,
	// random stalls, periodic stalls), and a requested hold-off wins.
	initial begin : result_sink
		int mode, mode_left, period, phase;

		result_ready = 1'b0;
		mode         = 0;
		mode_left    = 0;
		period       = 2;
		phase        = 0;
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				result_ready = 1'b0;
				hold_off--;
			end else begin
				if (mode_left == 0) begin
					mode      = $urandom_range(0, 2);
					mode_left = $urandom_range(20, 120);
					period    = $urandom_range(2, 7);
				end
				mode_left--;
				phase = (phase + 1) % period;
				case (mode)
					0:       result_ready = 1'b1;
					1:       result_ready = ($urandom_range(0, 3) != 0);
					default: result_ready = (phase != 0);
				endcase
			end
		end
	end

	// Every result beat is checked against the oldest one owed.
	always @(posedge clk) begin : result_check
		result_t want;

		if (arst_n && result_valid && result_ready) begin
			if (map_results_due.size() == 0) begin
				report_mismatch("result beat with none owed", {61'b0, status}, '0);
			end else begin
				want = map_results_due.pop_front();
				if (status != want.status)
					report_mismatch("status", {61'b0, status}, {61'b0, want.status});
				if (slot != want.slot)
					report_mismatch("slot", {60'b0, slot}, {60'b0, want.slot});
				if (address != want.address)
					report_mismatch("address", address, want.address);
			end
		end
	end

	initial begin
		arst_n        = 1'b0;
		item_valid    = 1'b0;
		command       = CMD_START;
		logical_block = '0;
		word_value    = '0;
		cfg_valid     = 1'b0;
		cfg_index     = CFG_LOG_BLOCK_SIZE;
		cfg_data      = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_direct_slots();
		test_indirect_levels();
		test_restart_hole_stray();
		test_register_extremes();
		test_config_mid_walk();
		test_output_backpressure();
		test_random_walks();

		// everything owed is back; give the two-stage pipe time to show
		// any stray beat
		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// run limit: far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
